// File: rtl/rx_fifo_with_rts_flow_control_macros.svh
// assertion macros for the receive fifo with rts flow control
`ifndef RX_FIFO_WITH_RTS_FLOW_CONTROL_MACROS_SVH
`define RX_FIFO_WITH_RTS_FLOW_CONTROL_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, clocked on clk, off during reset
`define RXF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rx fifo check failed");
// next-cycle implication, clocked on clk, off during reset
`define RXF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rx fifo check failed");
`else
`define RXF_ASSERT_IMP(lbl, ante, cons)
`define RXF_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// File: rtl/rxfifo_pkg.sv
// shared types and constants for the receive fifo with rts flow control
package rxfifo_pkg;

  localparam int DEPTH_DEF = 128;
  localparam int CFG_W     = 9;
  localparam int FREE_W    = 9;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_W-1:0] PAUSE_RST  = 9'd32;
  localparam logic [CFG_W-1:0] RESUME_RST = 9'd64;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PAUSE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESUME = 2'd1;

  // op codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [7:0]        read_byte;
    logic              read_valid;
    logic              overflow;
    logic              rts;
    logic [FREE_W-1:0] free_space;
    logic              char_available;
  } out_t;

endpackage

// File: rtl/rxfifo_mem.sv
// byte store: one write port, one read port with registered read data
module rxfifo_mem import rxfifo_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  localparam int IDX_W = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [7:0]       wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [7:0]       rd_data
);

  logic [7:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/rx_fifo_with_rts_flow_control.sv
// receive fifo with rts flow control and hysteresis, top level
// the result of a request is registered and shown from the cycle after it is taken
// throughput: one request per cycle, set by the registered pointer and count update
// and the registered read of the byte store; a stalled result stalls the input
// reset (rst_n low, synchronous): pointers 0, all entries free, rts low, thresholds
// 32 and 64; the byte store is not cleared and needs no clearing pass
module rx_fifo_with_rts_flow_control import rxfifo_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  `include "rx_fifo_with_rts_flow_control_macros.svh"

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [CFG_W-1:0] pause_r, resume_r;
  logic [IDX_W-1:0] wr_idx_r, wr_idx_nxt, rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0] space_r, space_nxt;
  logic             rts_r, rts_nxt;
  logic             acc, push_ok, pop_ok;
  logic [FREE_W-1:0] space_dec, space_inc;

  logic              out_valid_r;
  logic              rvalid_r, ovf_r, avail_r;
  logic [FREE_W-1:0] free_r;
  logic [7:0]        rd_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pause_r  <= PAUSE_RST;
      resume_r <= RESUME_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PAUSE:  pause_r  <= cfg_wdata;
        REG_RESUME: resume_r <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  // request handshake
  assign in_stall = out_valid_r && out_stall;
  assign acc      = in_valid && !in_stall;
  assign push_ok  = acc && (in_data.op == OP_PUSH) && (space_r != '0);
  assign pop_ok   = acc && (in_data.op == OP_POP) && (space_r != FULL_CNT);

  assign space_dec = FREE_W'(space_r) - FREE_W'(1);
  assign space_inc = FREE_W'(space_r) + FREE_W'(1);

  // pointer, free count and rts update
  always_comb begin
    wr_idx_nxt = wr_idx_r;
    rd_idx_nxt = rd_idx_r;
    space_nxt  = space_r;
    rts_nxt    = rts_r;
    if (push_ok) begin
      wr_idx_nxt = (wr_idx_r == LAST_IDX) ? '0 : wr_idx_r + IDX_W'(1);
      space_nxt  = space_r - CNT_W'(1);
      if (!rts_r && (space_dec < pause_r)) begin
        rts_nxt = 1'b1;
      end
    end else if (pop_ok) begin
      rd_idx_nxt = (rd_idx_r == LAST_IDX) ? '0 : rd_idx_r + IDX_W'(1);
      space_nxt  = space_r + CNT_W'(1);
      if (rts_r && (space_inc > resume_r)) begin
        rts_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      space_r  <= FULL_CNT;
      rts_r    <= 1'b0;
    end else begin
      wr_idx_r <= wr_idx_nxt;
      rd_idx_r <= rd_idx_nxt;
      space_r  <= space_nxt;
      rts_r    <= rts_nxt;
    end
  end

  // byte store
  rxfifo_mem #(.DEPTH(DEPTH)) u_mem (
    .clk     (clk),
    .wr_en   (push_ok),
    .wr_addr (wr_idx_r),
    .wr_data (in_data.rx_byte),
    .rd_en   (pop_ok),
    .rd_addr (rd_idx_r),
    .rd_data (rd_data)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rvalid_r <= pop_ok;
      ovf_r    <= (in_data.op == OP_PUSH) && (space_r == '0);
      free_r   <= FREE_W'(space_nxt);
      avail_r  <= (space_nxt != FULL_CNT);
    end
  end

  assign out_valid                = out_valid_r;
  assign out_data.read_byte       = rvalid_r ? rd_data : 8'd0;
  assign out_data.read_valid      = rvalid_r;
  assign out_data.overflow        = ovf_r;
  assign out_data.rts             = rts_r;
  assign out_data.free_space      = free_r;
  assign out_data.char_available  = avail_r;

  // checks
  `RXF_ASSERT_IMP(a_no_ovf_and_read, out_valid_r, !(ovf_r && rvalid_r))
  `RXF_ASSERT_NXT(a_full_push_holds, acc && (in_data.op == OP_PUSH) && (space_r == '0), $stable(space_r) && ovf_r)
  `RXF_ASSERT_NXT(a_pop_gives_byte, pop_ok, out_valid_r && rvalid_r && (space_r != '0))
  `RXF_ASSERT_IMP(a_rts_rise_on_push, $rose(rts_r), $past(push_ok))

endmodule
